FILE: design/fbc_pkg.sv
// Package for the frustum box cull unit: widths, plane operation codes,
// the control word types and the microprogram table.
// Depends on nothing; used by frustum_box_cull_unit and fbc_datapath.
package fbc_pkg;

    localparam int ELEM_W     = 32;
    localparam int EXT_W      = 31;
    localparam int PL_W       = ELEM_W + 1;
    localparam int P1_W       = PL_W + ELEM_W;
    localparam int P2_W       = PL_W + EXT_W;
    localparam int ACC_W      = 68;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 6;
    localparam int STEP_W     = 3;
    localparam int PLANE_W    = 3;
    localparam int ROW_W      = 2;
    localparam int AXIS_W     = 2;
    localparam int FRAC_BITS  = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_PASS
    } t_plane_op;

    typedef struct packed {
        logic              rd;
        logic              form;
        logic              mul;
        logic [AXIS_W-1:0] axis;
        logic              acc_init;
        logic              acc_add;
        logic              test;
        logic              last;
    } t_uword;

    typedef struct packed {
        t_uword           uw;
        t_plane_op        op;
        logic [ROW_W-1:0] row_sel;
    } t_ctrl;

    localparam logic [AXIS_W-1:0] AX_X = 2'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

    // One plane takes six steps: read the two rows, form the plane, three
    // multiply steps that overlap the accumulation, and a final add with test.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        begin
            w = '0;
            unique case (step)
                3'd0: begin
                    w.rd = 1'b1;
                end
                3'd1: begin
                    w.form = 1'b1;
                end
                3'd2: begin
                    w.mul      = 1'b1;
                    w.axis     = AX_X;
                    w.acc_init = 1'b1;
                end
                3'd3: begin
                    w.mul     = 1'b1;
                    w.axis    = AX_Y;
                    w.acc_add = 1'b1;
                end
                3'd4: begin
                    w.mul     = 1'b1;
                    w.axis    = AX_Z;
                    w.acc_add = 1'b1;
                end
                3'd5: begin
                    w.acc_add = 1'b1;
                    w.test    = 1'b1;
                    w.last    = 1'b1;
                end
                default: begin
                    w.last = 1'b1;
                end
            endcase
            return w;
        end
    endfunction

    function automatic t_plane_op plane_op(input logic [PLANE_W-1:0] plane);
        t_plane_op op;
        begin
            unique case (plane)
                3'd0, 3'd2: op = OP_ADD;
                3'd4:       op = OP_PASS;
                default:    op = OP_SUB;
            endcase
            return op;
        end
    endfunction

    function automatic logic [ROW_W-1:0] plane_row(input logic [PLANE_W-1:0] plane);
        return ROW_W'(plane >> 1);
    endfunction

endpackage

FILE: design/frustum_box_cull_unit.sv
// Top level of the frustum box cull unit: command port, microcode sequencer
// and result register. Depends on fbc_pkg and instantiates fbc_datapath.
//
// Usage: a command is taken at a rising edge where start is high and busy is
// low. A load command (i_command 0) writes the four elements of row
// i_row_index of the view-projection matrix in that same edge; it gives no
// result and busy stays low, so loads may follow each other every cycle.
// A test command (i_command 1) takes a box as center and half-extents and
// raises busy while it runs six planes, each by a six-step microprogram
// (row read, plane forming, three multiply steps on one shared pair of
// multipliers, and a final add with sign test). In the cycle after the last
// step o_valid is high for one cycle with o_visible, and busy is already low,
// so the next command can already be taken in that same cycle. A new box is
// taken only after the previous test has finished, since busy stays high
// through the whole plane loop.
// The receiver cannot hold a result off; o_valid is a one-cycle strobe.
// Reset empties the matrix storage (all rows read as zero, so every box is
// visible), stops any test in progress and drops busy and o_valid.
module frustum_box_cull_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [1:0]  i_row_index,
    input  logic [31:0] i_row_x,
    input  logic [31:0] i_row_y,
    input  logic [31:0] i_row_z,
    input  logic [31:0] i_row_w,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic [30:0] i_extent_x,
    input  logic [30:0] i_extent_y,
    input  logic [30:0] i_extent_z,
    output logic        o_valid,
    output logic        o_visible
);
    import fbc_pkg::*;

    logic               r_busy;
    logic [STEP_W-1:0]  r_step;
    logic [PLANE_W-1:0] r_plane;
    logic               r_vis;
    logic               accept;
    logic               neg;
    logic               n_vis;
    t_uword             uw;
    t_ctrl              ctrl;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        uw           = ucode(r_step);
        ctrl.uw      = r_busy ? uw : t_uword'('0);
        ctrl.op      = plane_op(r_plane);
        ctrl.row_sel = plane_row(r_plane);
        n_vis        = r_vis && !neg;
    end

    fbc_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_wr_en   (accept && (i_command == CMD_LOAD)),
        .i_wr_row  (i_row_index),
        .i_wr_data ({i_row_w, i_row_z, i_row_y, i_row_x}),
        .i_box_ld  (accept && (i_command == CMD_TEST)),
        .i_center  ({i_center_z, i_center_y, i_center_x}),
        .i_extent  ({i_extent_z, i_extent_y, i_extent_x}),
        .o_neg     (neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_plane   <= '0;
            r_vis     <= 1'b1;
            o_valid   <= 1'b0;
            o_visible <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (!r_busy) begin
                if (accept && (i_command == CMD_TEST)) begin
                    r_busy  <= 1'b1;
                    r_step  <= '0;
                    r_plane <= '0;
                    r_vis   <= 1'b1;
                end
            end else begin
                if (uw.test) begin
                    r_vis <= n_vis;
                end
                if (uw.last) begin
                    r_step <= '0;
                    if (r_plane == PLANE_W'(NUM_PLANES - 1)) begin
                        r_busy    <= 1'b0;
                        o_valid   <= 1'b1;
                        o_visible <= uw.test ? n_vis : r_vis;
                    end else begin
                        r_plane <= r_plane + 1'b1;
                    end
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/fbc_datapath.sv
// Datapath of the frustum box cull unit: matrix row memory, plane former,
// shared multipliers and the wide accumulator with its sign test.
// Depends on fbc_pkg; driven by the sequencer in frustum_box_cull_unit.
module fbc_datapath (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  fbc_pkg::t_ctrl                                     i_ctrl,
    input  logic                                               i_wr_en,
    input  logic [fbc_pkg::ROW_W-1:0]                          i_wr_row,
    input  logic [fbc_pkg::NUM_ROWS-1:0][fbc_pkg::ELEM_W-1:0]  i_wr_data,
    input  logic                                               i_box_ld,
    input  logic [fbc_pkg::NUM_AXES-1:0][fbc_pkg::ELEM_W-1:0]  i_center,
    input  logic [fbc_pkg::NUM_AXES-1:0][fbc_pkg::EXT_W-1:0]   i_extent,
    output logic                                               o_neg
);
    import fbc_pkg::*;

    logic [NUM_ROWS-1:0][ELEM_W-1:0] r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]             r_vld;
    logic [NUM_ROWS-1:0][ELEM_W-1:0] r_rd3;
    logic [NUM_ROWS-1:0][ELEM_W-1:0] r_rdr;
    logic [NUM_AXES-1:0][ELEM_W-1:0] r_ctr;
    logic [NUM_AXES-1:0][EXT_W-1:0]  r_ext;
    logic signed [PL_W-1:0]          r_pl [NUM_ROWS];
    logic signed [PL_W-1:0]          n_pl [NUM_ROWS];
    logic signed [P1_W-1:0]          r_p1;
    logic [P2_W-1:0]                 r_p2;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]         sum;
    logic signed [PL_W-1:0]          pl_sel;
    logic signed [ELEM_W-1:0]        c_sel;
    logic [EXT_W-1:0]                e_sel;
    logic [PL_W-1:0]                 pl_mag;
    logic [PL_W-1:0]                 a33;
    logic [PL_W-1:0]                 b33;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_ctrl.uw.rd) begin
            r_rd3 <= r_vld[NUM_ROWS-1] ? r_mem[NUM_ROWS-1] : '0;
            r_rdr <= r_vld[i_ctrl.row_sel] ? r_mem[i_ctrl.row_sel] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_row] <= 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_ROWS; k++) begin
            a33 = {r_rd3[k][ELEM_W-1], r_rd3[k]};
            b33 = {r_rdr[k][ELEM_W-1], r_rdr[k]};
            unique case (i_ctrl.op)
                OP_ADD:  n_pl[k] = a33 + b33;
                OP_SUB:  n_pl[k] = a33 - b33;
                OP_PASS: n_pl[k] = b33;
                default: n_pl[k] = b33;
            endcase
        end
    end

    always_comb begin
        pl_sel = r_pl[i_ctrl.uw.axis];
        c_sel  = r_ctr[i_ctrl.uw.axis];
        e_sel  = r_ext[i_ctrl.uw.axis];
        pl_mag = pl_sel[PL_W-1] ? PL_W'(-pl_sel) : PL_W'(pl_sel);
        sum    = r_acc + ACC_W'(r_p1) + ACC_W'(r_p2);
    end

    assign o_neg = sum[ACC_W-1];

    always_ff @(posedge i_clk) begin
        if (i_box_ld) begin
            r_ctr <= i_center;
            r_ext <= i_extent;
        end
        if (i_ctrl.uw.form) begin
            r_pl <= n_pl;
        end
        if (i_ctrl.uw.mul) begin
            r_p1 <= P1_W'(pl_sel) * P1_W'(c_sel);
            r_p2 <= P2_W'(pl_mag) * P2_W'(e_sel);
        end
        if (i_ctrl.uw.acc_init) begin
            r_acc <= {{(ACC_W - PL_W - FRAC_BITS){r_pl[NUM_ROWS-1][PL_W-1]}},
                      r_pl[NUM_ROWS-1], {FRAC_BITS{1'b0}}};
        end else if (i_ctrl.uw.acc_add) begin
            r_acc <= sum;
        end
    end

endmodule

FILE: design/fbc_checker.sv
// Port-level checker for the frustum box cull unit and its bind statement.
// Depends only on the ports of frustum_box_cull_unit.
module fbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_valid
);

    a_test_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command) |=> busy)
        else $error("test request did not raise busy");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command) |=> (!busy && !o_valid))
        else $error("load request raised busy or gave a result");

    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe not at the end of a busy period");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind frustum_box_cull_unit fbc_checker u_fbc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_valid   (o_valid)
);
